[rtl/bpc_pkg.sv]
// shared constants, types and arithmetic helpers for the barometric compensation core
// no dependencies
package bpc_pkg;

   localparam int DIV_W = 32;
   localparam int NUM_CFG = 6;
   localparam int ADDR_W = 5;

   localparam logic [2:0] REG_AC1_AC2 = 3'd0;
   localparam logic [2:0] REG_AC3_AC4 = 3'd1;
   localparam logic [2:0] REG_AC5_AC6 = 3'd2;
   localparam logic [2:0] REG_B1_B2 = 3'd3;
   localparam logic [2:0] REG_MC_MD = 3'd4;
   localparam logic [2:0] REG_OSS = 3'd5;

   localparam logic signed [31:0] TEMP_OFFSET = 32'sd4000;
   localparam logic [31:0] PRESS_NUM = 32'd50000;
   localparam logic signed [31:0] PC1 = 32'sd3038;
   localparam logic signed [31:0] PC2 = -32'sd7357;
   localparam logic signed [31:0] PC3 = 32'sd3791;
   localparam logic signed [31:0] HALF_B4 = 32'sd32768;
   localparam logic signed [31:0] TEMP_MAX = 32'sd32767;
   localparam logic signed [31:0] TEMP_MIN = -32'sd32768;
   localparam logic signed [31:0] PRESS_MAX = 32'sd1048575;

   typedef struct packed {
      logic signed [15:0] temp;
      logic fault;
   } side_type;

   // low 32 bits of a 32 by 32 product
   function automatic logic signed [31:0] mul32(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
      logic signed [63:0] p;
      p = a * b;
      return p[31:0];
   endfunction

   // signed division by 2**k, truncating toward zero
   function automatic logic signed [31:0] sdiv_p2(input logic signed [31:0] a,
                                                  input int unsigned k);
      logic signed [31:0] bias;
      bias = a[31] ? ((32'sd1 <<< k) - 32'sd1) : 32'sd0;
      return (a + bias) >>> k;
   endfunction

endpackage

[rtl/barometric_pressure_compensation_core.sv]
// top level of the barometric compensation core: register file and compensation pipeline
// depends on bpc_pkg and bpc_udiv
//
// channel   direction  handshake              payload
// req       in         req_valid/req_ready    req_raw_temperature, req_raw_pressure
// rsp       out        rsp_valid/rsp_ready    rsp_temperature, rsp_pressure, rsp_fault
// csr       in/out     psel/penable/pready    paddr, pwrite, pwdata, prdata
//
// one request per cycle unless the output stalls; most of the pipeline is the two
// one-bit-per-stage dividers (temperature and pressure quotients)
// reset is synchronous and clears valid bits and calibration registers
// a stalled output freezes the whole pipeline, no request is lost or repeated
module barometric_pressure_compensation_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [15:0]                   req_raw_temperature,
   input  logic [23:0]                   req_raw_pressure,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [15:0]            rsp_temperature,
   output logic [19:0]                   rsp_pressure,
   output logic                          rsp_fault,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [bpc_pkg::ADDR_W-1:0]    paddr,
   input  logic [31:0]                   pwdata,
   output logic [31:0]                   prdata,
   output logic                          pready
);
   import bpc_pkg::*;

   // register file
   logic [31:0] cfg_ff [NUM_CFG];
   logic [2:0] widx;
   assign pready = 1'b1;
   assign widx = paddr[ADDR_W-1:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_CFG; i++) cfg_ff[i] <= '0;
      end else if (psel && penable && pwrite) begin
         unique case (widx)
            REG_AC1_AC2: cfg_ff[0] <= pwdata;
            REG_AC3_AC4: cfg_ff[1] <= pwdata;
            REG_AC5_AC6: cfg_ff[2] <= pwdata;
            REG_B1_B2:   cfg_ff[3] <= pwdata;
            REG_MC_MD:   cfg_ff[4] <= pwdata;
            REG_OSS:     cfg_ff[5] <= {30'd0, pwdata[1:0]};
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (widx)
         REG_AC1_AC2: prdata = cfg_ff[0];
         REG_AC3_AC4: prdata = cfg_ff[1];
         REG_AC5_AC6: prdata = cfg_ff[2];
         REG_B1_B2:   prdata = cfg_ff[3];
         REG_MC_MD:   prdata = cfg_ff[4];
         REG_OSS:     prdata = cfg_ff[5];
         default:     prdata = '0;
      endcase
   end

   logic signed [31:0] ac1, ac2, ac3, b1, b2, mc, md;
   logic [31:0] ac4, ac5, ac6;
   logic [1:0] oss;
   assign ac1 = {{16{cfg_ff[0][31]}}, cfg_ff[0][31:16]};
   assign ac2 = {{16{cfg_ff[0][15]}}, cfg_ff[0][15:0]};
   assign ac3 = {{16{cfg_ff[1][31]}}, cfg_ff[1][31:16]};
   assign ac4 = {16'd0, cfg_ff[1][15:0]};
   assign ac5 = {16'd0, cfg_ff[2][31:16]};
   assign ac6 = {16'd0, cfg_ff[2][15:0]};
   assign b1 = {{16{cfg_ff[3][31]}}, cfg_ff[3][31:16]};
   assign b2 = {{16{cfg_ff[3][15]}}, cfg_ff[3][15:0]};
   assign mc = {{16{cfg_ff[4][31]}}, cfg_ff[4][31:16]};
   assign md = {{16{cfg_ff[4][15]}}, cfg_ff[4][15:0]};
   assign oss = cfg_ff[5][1:0];

   logic en;
   logic rsp_valid_ff;
   assign en = !rsp_valid_ff || rsp_ready;
   assign req_ready = en;

   // stage 1
   logic v1_ff;
   logic signed [31:0] s1_p_ff;
   logic [23:0] s1_up_ff;
   always_ff @(posedge clock) begin
      if (reset) v1_ff <= 1'b0;
      else if (en) v1_ff <= req_valid;
      if (en) begin
         s1_p_ff <= mul32($signed({16'd0, req_raw_temperature} - ac6), $signed(ac5));
         s1_up_ff <= req_raw_pressure >> (4'd8 - {2'd0, oss});
      end
   end

   // stage 2 feeds the temperature divider
   logic signed [31:0] s2_x1, s2_den, s2_num;
   logic [31:0] s2_na, s2_da, qa;
   logic s2_neg;
   assign s2_x1 = sdiv_p2(s1_p_ff, 15);
   assign s2_den = s2_x1 + md;
   assign s2_num = mc <<< 11;
   assign s2_na = s2_num[31] ? 32'(-s2_num) : s2_num;
   assign s2_da = s2_den[31] ? 32'(-s2_den) : s2_den;
   assign s2_neg = s2_num[31] ^ s2_den[31];

   bpc_udiv u_div_t (
      .clock(clock), .en(en), .dividend(s2_na), .divisor(s2_da), .quotient(qa)
   );

   typedef struct packed {
      logic v;
      logic fault;
      logic neg;
      logic signed [31:0] x1;
      logic [23:0] up;
   } dla_type;
   dla_type dla_ff [DIV_W];
   dla_type dla_in;
   assign dla_in = '{v: v1_ff, fault: (s2_den == 32'sd0), neg: s2_neg, x1: s2_x1,
                     up: s1_up_ff};
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DIV_W; i++) dla_ff[i].v <= 1'b0;
      end else if (en) begin
         dla_ff[0].v <= dla_in.v;
         for (int i = 1; i < DIV_W; i++) dla_ff[i].v <= dla_ff[i-1].v;
      end
      if (en) begin
         dla_ff[0].fault <= dla_in.fault;
         dla_ff[0].neg <= dla_in.neg;
         dla_ff[0].x1 <= dla_in.x1;
         dla_ff[0].up <= dla_in.up;
         for (int i = 1; i < DIV_W; i++) begin
            dla_ff[i].fault <= dla_ff[i-1].fault;
            dla_ff[i].neg <= dla_ff[i-1].neg;
            dla_ff[i].x1 <= dla_ff[i-1].x1;
            dla_ff[i].up <= dla_ff[i-1].up;
         end
      end
   end

   // stage 3
   logic signed [31:0] s3_x2, s3_b5, s3_t;
   logic signed [15:0] s3_t16;
   assign s3_x2 = dla_ff[DIV_W-1].neg ? -$signed(qa) : $signed(qa);
   assign s3_b5 = dla_ff[DIV_W-1].x1 + s3_x2;
   assign s3_t = sdiv_p2(s3_b5 + 32'sd8, 4);
   assign s3_t16 = (s3_t > TEMP_MAX) ? 16'sh7fff :
                   (s3_t < TEMP_MIN) ? 16'sh8000 : s3_t[15:0];

   logic v3_ff, v4_ff, v5_ff, v6_ff, v7_ff, v8_ff, v9_ff;
   side_type sd3_ff, sd4_ff, sd5_ff, sd6_ff, sd7_ff, sd8_ff, sd9_ff;
   logic [23:0] up3_ff, up4_ff, up5_ff, up6_ff, up7_ff, up8_ff;
   logic signed [31:0] b6_ff;
   logic signed [31:0] sqp_ff, ac2b6_ff, ac3b6_ff;
   logic signed [31:0] sq_ff, x2a_ff, x1c_ff;
   logic signed [31:0] b2sq_ff, b1sq_ff, x2a6_ff, x1c6_ff;
   logic signed [31:0] b3pre_ff, x3c_ff;
   logic signed [31:0] b3_ff, b4p_ff;
   logic [31:0] b4_ff, b7_ff;
   logic signed [31:0] s7_x3;

   assign s7_x3 = sdiv_p2(b2sq_ff, 11) + x2a6_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0; v4_ff <= 1'b0; v5_ff <= 1'b0; v6_ff <= 1'b0;
         v7_ff <= 1'b0; v8_ff <= 1'b0; v9_ff <= 1'b0;
      end else if (en) begin
         v3_ff <= dla_ff[DIV_W-1].v;
         v4_ff <= v3_ff; v5_ff <= v4_ff; v6_ff <= v5_ff;
         v7_ff <= v6_ff; v8_ff <= v7_ff; v9_ff <= v8_ff;
      end
      if (en) begin
         sd3_ff <= '{temp: s3_t16, fault: dla_ff[DIV_W-1].fault};
         up3_ff <= dla_ff[DIV_W-1].up;
         b6_ff <= s3_b5 - TEMP_OFFSET;
         // stage 4
         sd4_ff <= sd3_ff; up4_ff <= up3_ff;
         sqp_ff <= mul32(b6_ff, b6_ff);
         ac2b6_ff <= mul32(ac2, b6_ff);
         ac3b6_ff <= mul32(ac3, b6_ff);
         // stage 5
         sd5_ff <= sd4_ff; up5_ff <= up4_ff;
         sq_ff <= sdiv_p2(sqp_ff, 12);
         x2a_ff <= sdiv_p2(ac2b6_ff, 11);
         x1c_ff <= sdiv_p2(ac3b6_ff, 13);
         // stage 6
         sd6_ff <= sd5_ff; up6_ff <= up5_ff;
         b2sq_ff <= mul32(b2, sq_ff);
         b1sq_ff <= mul32(b1, sq_ff);
         x2a6_ff <= x2a_ff;
         x1c6_ff <= x1c_ff;
         // stage 7
         sd7_ff <= sd6_ff; up7_ff <= up6_ff;
         b3pre_ff <= ((ac1 <<< 2) + s7_x3) <<< oss;
         x3c_ff <= sdiv_p2(x1c6_ff + sdiv_p2(b1sq_ff, 16) + 32'sd2, 2);
         // stage 8
         sd8_ff <= sd7_ff; up8_ff <= up7_ff;
         b3_ff <= sdiv_p2(b3pre_ff + 32'sd2, 2);
         b4p_ff <= mul32($signed(ac4), x3c_ff + HALF_B4);
         // stage 9
         b4_ff <= {15'd0, b4p_ff[31:15]};
         b7_ff <= mul32($signed({8'd0, up8_ff} - b3_ff), $signed(PRESS_NUM >> oss));
         sd9_ff <= '{temp: sd8_ff.temp, fault: sd8_ff.fault || (b4p_ff[31:15] == 17'd0)};
      end
   end

   // pressure divider
   logic s9_small;
   logic [31:0] s9_a, qb;
   assign s9_small = !b7_ff[31];
   assign s9_a = s9_small ? {b7_ff[30:0], 1'b0} : b7_ff;

   bpc_udiv u_div_p (
      .clock(clock), .en(en), .dividend(s9_a), .divisor(b4_ff), .quotient(qb)
   );

   typedef struct packed {
      logic v;
      logic pre2;
      side_type sd;
   } dlb_type;
   dlb_type dlb_ff [DIV_W];
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DIV_W; i++) dlb_ff[i].v <= 1'b0;
      end else if (en) begin
         dlb_ff[0].v <= v9_ff;
         for (int i = 1; i < DIV_W; i++) dlb_ff[i].v <= dlb_ff[i-1].v;
      end
      if (en) begin
         dlb_ff[0].pre2 <= s9_small;
         dlb_ff[0].sd <= sd9_ff;
         for (int i = 1; i < DIV_W; i++) begin
            dlb_ff[i].pre2 <= dlb_ff[i-1].pre2;
            dlb_ff[i].sd <= dlb_ff[i-1].sd;
         end
      end
   end

   // stages 10 to 13
   logic signed [31:0] s10_p;
   assign s10_p = dlb_ff[DIV_W-1].pre2 ? $signed(qb) : $signed({qb[30:0], 1'b0});

   logic v10_ff, v11_ff, v12_ff, v13_ff;
   side_type sd10_ff, sd11_ff, sd12_ff, sd13_ff;
   logic signed [31:0] p10_ff, x110_ff, x2m_ff;
   logic signed [31:0] p11_ff, x1sq_ff, x211_ff;
   logic signed [31:0] p12_ff, x1m_ff, x212_ff;
   logic signed [31:0] p13_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v10_ff <= 1'b0; v11_ff <= 1'b0; v12_ff <= 1'b0; v13_ff <= 1'b0;
      end else if (en) begin
         v10_ff <= dlb_ff[DIV_W-1].v;
         v11_ff <= v10_ff; v12_ff <= v11_ff; v13_ff <= v12_ff;
      end
      if (en) begin
         sd10_ff <= dlb_ff[DIV_W-1].sd;
         p10_ff <= s10_p;
         x110_ff <= sdiv_p2(s10_p, 8);
         x2m_ff <= mul32(PC2, s10_p);
         sd11_ff <= sd10_ff; p11_ff <= p10_ff;
         x1sq_ff <= mul32(x110_ff, x110_ff);
         x211_ff <= sdiv_p2(x2m_ff, 16);
         sd12_ff <= sd11_ff; p12_ff <= p11_ff; x212_ff <= x211_ff;
         x1m_ff <= mul32(x1sq_ff, PC1);
         sd13_ff <= sd12_ff;
         p13_ff <= p12_ff + sdiv_p2(sdiv_p2(x1m_ff, 16) + x212_ff + PC3, 4);
      end
   end

   // output register
   logic signed [15:0] rsp_temperature_ff;
   logic [19:0] rsp_pressure_ff;
   logic rsp_fault_ff;
   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (en) rsp_valid_ff <= v13_ff;
      if (en) begin
         rsp_fault_ff <= sd13_ff.fault;
         rsp_temperature_ff <= sd13_ff.fault ? 16'sd0 : sd13_ff.temp;
         if (sd13_ff.fault || p13_ff < 32'sd0) rsp_pressure_ff <= '0;
         else if (p13_ff > PRESS_MAX) rsp_pressure_ff <= 20'hfffff;
         else rsp_pressure_ff <= p13_ff[19:0];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_temperature = rsp_temperature_ff;
   assign rsp_pressure = rsp_pressure_ff;
   assign rsp_fault = rsp_fault_ff;

   a_fault_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_fault |-> rsp_temperature == 16'sd0 && rsp_pressure == 20'd0)
      else $error("fault result carries nonzero fields");
   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid && !v1_ff && !v13_ff)
      else $error("valid bits survive reset");
   a_stall_freeze: assert property (@(posedge clock) disable iff (reset)
      !req_ready |=> $stable(v13_ff) && $stable(p13_ff) && $stable(v1_ff))
      else $error("pipeline moved during stall");
   a_ready_rule: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("request taken while output blocked");

endmodule

[rtl/bpc_udiv.sv]
// pipelined unsigned restoring divider, one quotient bit per stage
// depends on bpc_pkg
module bpc_udiv (
   input  logic                       clock,
   input  logic                       en,
   input  logic [bpc_pkg::DIV_W-1:0]  dividend,
   input  logic [bpc_pkg::DIV_W-1:0]  divisor,
   output logic [bpc_pkg::DIV_W-1:0]  quotient
);
   import bpc_pkg::*;

   logic [DIV_W-1:0] rem_ff [DIV_W];
   logic [DIV_W-1:0] num_ff [DIV_W];
   logic [DIV_W-1:0] den_ff [DIV_W];
   logic [DIV_W-1:0] quo_ff [DIV_W];
   logic [DIV_W-1:0] rem_in [DIV_W];
   logic [DIV_W-1:0] num_in [DIV_W];
   logic [DIV_W-1:0] den_in [DIV_W];
   logic [DIV_W-1:0] quo_in [DIV_W];

   always_comb begin
      for (int i = 0; i < DIV_W; i++) begin
         logic [DIV_W-1:0] r;
         logic [DIV_W-1:0] n;
         logic [DIV_W-1:0] d;
         logic [DIV_W-1:0] q;
         logic [DIV_W:0] sh;
         logic [DIV_W:0] diff;
         if (i == 0) begin
            r = '0;
            n = dividend;
            d = divisor;
            q = '0;
         end else begin
            r = rem_ff[i-1];
            n = num_ff[i-1];
            d = den_ff[i-1];
            q = quo_ff[i-1];
         end
         sh = {r, n[DIV_W-1]};
         diff = sh - {1'b0, d};
         if (!diff[DIV_W]) begin
            rem_in[i] = diff[DIV_W-1:0];
            quo_in[i] = {q[DIV_W-2:0], 1'b1};
         end else begin
            rem_in[i] = sh[DIV_W-1:0];
            quo_in[i] = {q[DIV_W-2:0], 1'b0};
         end
         num_in[i] = {n[DIV_W-2:0], 1'b0};
         den_in[i] = d;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < DIV_W; i++) begin
            rem_ff[i] <= rem_in[i];
            num_ff[i] <= num_in[i];
            den_ff[i] <= den_in[i];
            quo_ff[i] <= quo_in[i];
         end
      end
   end

   assign quotient = quo_ff[DIV_W-1];

endmodule

[dv/barometric_pressure_compensation_core_tb.sv]
// self-checking testbench for the barometric pressure compensation core
// depends on bpc_pkg and barometric_pressure_compensation_core
module barometric_pressure_compensation_core_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import bpc_pkg::*;

   typedef struct packed {
      logic [15:0] raw_t;
      logic [23:0] raw_p;
   } reading_type;

   typedef struct packed {
      logic signed [15:0] temp;
      logic [19:0] press;
      logic fault;
   } comp_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [15:0] req_raw_temperature = '0;
   logic [23:0] req_raw_pressure = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [15:0] rsp_temperature;
   logic [19:0] rsp_pressure;
   logic rsp_fault;
   logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
   logic [ADDR_W-1:0] paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic pready;

   barometric_pressure_compensation_core u_top (.*);

   always #4 clock = ~clock;

   logic [31:0] cal [NUM_CFG];
   reading_type pending_readings[$];
   comp_type expected_comp[$];
   int mismatches = 0;
   int checked = 0;
   int faults_seen = 0;
   bit calm = 1'b0;
   int send_gap = 0, recv_gap = 0;

   function automatic logic signed [31:0] tdiv(logic signed [31:0] a, logic signed [31:0] b);
      logic signed [63:0] q;
      q = 64'(a) / 64'(b);
      return q[31:0];
   endfunction

   function automatic comp_type compensate(reading_type r);
      logic signed [31:0] ac1, ac2, ac3, ac5, ac6, b1, b2, mc, md;
      logic [31:0] ac4, up, b4, b7, q;
      logic [1:0] oss;
      logic signed [31:0] x1, x2, x3, b3, b5, b6, sq, den, t, p, ut;
      comp_type c;
      ac1 = 32'(signed'(cal[0][31:16]));
      ac2 = 32'(signed'(cal[0][15:0]));
      ac3 = 32'(signed'(cal[1][31:16]));
      ac4 = {16'd0, cal[1][15:0]};
      ac5 = {16'd0, cal[2][31:16]};
      ac6 = {16'd0, cal[2][15:0]};
      b1 = 32'(signed'(cal[3][31:16]));
      b2 = 32'(signed'(cal[3][15:0]));
      mc = 32'(signed'(cal[4][31:16]));
      md = 32'(signed'(cal[4][15:0]));
      oss = cal[5][1:0];
      ut = {16'd0, r.raw_t};
      up = {8'd0, r.raw_p} >> (8 - oss);
      c = '{temp: '0, press: '0, fault: 1'b1};
      x1 = tdiv((ut - ac6) * ac5, 32768);
      den = x1 + md;
      if (den == 0) return c;
      x2 = tdiv(mc * 2048, den);
      b5 = x1 + x2;
      t = tdiv(b5 + 8, 16);
      b6 = b5 - 4000;
      sq = tdiv(b6 * b6, 4096);
      x1 = tdiv(b2 * sq, 2048);
      x2 = tdiv(ac2 * b6, 2048);
      x3 = x1 + x2;
      b3 = (ac1 * 4 + x3) << oss;
      b3 = tdiv(b3 + 2, 4);
      x1 = tdiv(ac3 * b6, 8192);
      x2 = tdiv(b1 * sq, 65536);
      x3 = tdiv(x1 + x2 + 2, 4);
      b4 = (ac4 * 32'(x3 + 32768)) / 32'd32768;
      if (b4 == 0) return c;
      b7 = (up - 32'(b3)) * (32'd50000 >> oss);
      if (b7 < 32'h8000_0000) q = (b7 * 2) / b4;
      else q = (b7 / b4) * 2;
      p = q;
      x1 = tdiv(p, 256);
      x1 = x1 * x1;
      x1 = tdiv(x1 * 3038, 65536);
      x2 = tdiv(-32'sd7357 * p, 65536);
      p = p + tdiv(x1 + x2 + 3791, 16);
      if (t > 32767) t = 32767;
      if (t < -32768) t = -32768;
      if (p < 0) p = 0;
      if (p > 1048575) p = 1048575;
      c.temp = t[15:0];
      c.press = p[19:0];
      c.fault = 1'b0;
      return c;
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (req_valid) expected_comp.push_back(compensate({req_raw_temperature,
            req_raw_pressure}));
         if (send_gap > 0) begin
            send_gap <= send_gap - 1;
            req_valid <= 1'b0;
         end else if (pending_readings.size() > 0) begin
            reading_type r;
            r = pending_readings.pop_front();
            req_valid <= 1'b1;
            req_raw_temperature <= r.raw_t;
            req_raw_pressure <= r.raw_p;
            if (!calm && $urandom_range(0, 9) == 0) send_gap <= $urandom_range(1, 10);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            comp_type e;
            if (expected_comp.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected result t=%0d p=%0d f=%0b",
                  rsp_temperature, rsp_pressure, rsp_fault);
            end else begin
               e = expected_comp.pop_front();
               checked++;
               if (rsp_fault) faults_seen++;
               if (e.temp !== rsp_temperature || e.press !== rsp_pressure ||
                   e.fault !== rsp_fault) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch exp t=%0d p=%0d f=%0b got t=%0d p=%0d f=%0b",
                        e.temp, e.press, e.fault, rsp_temperature, rsp_pressure,
                        rsp_fault);
               end
            end
         end
         if (recv_gap > 0) begin
            recv_gap <= recv_gap - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            if (!calm && $urandom_range(0, 9) == 0) recv_gap <= $urandom_range(1, 10);
         end
      end
   end

   task automatic csr_write(int idx, logic [31:0] v);
      @(posedge clock);
      psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
      paddr <= ADDR_W'(4 * idx); pwdata <= v;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
      cal[idx] = (idx == REG_OSS) ? (v & 32'd3) : v;
   endtask

   task automatic drain();
      do @(negedge clock);
      while (pending_readings.size() != 0 || req_valid || expected_comp.size() != 0);
      repeat (100) @(posedge clock);
   endtask

   task automatic load_typical(logic [1:0] oss);
      csr_write(REG_AC1_AC2, {16'd408, -16'sd72});
      csr_write(REG_AC3_AC4, {-16'sd14383, 16'd32741});
      csr_write(REG_AC5_AC6, {16'd32757, 16'd23153});
      csr_write(REG_B1_B2, {16'd6190, 16'd4});
      csr_write(REG_MC_MD, {-16'sd8711, 16'd2868});
      csr_write(REG_OSS, {30'd0, oss});
   endtask

   task automatic queue_random(int n, bit plausible);
      repeat (n) begin
         if (plausible)
            pending_readings.push_back({16'($urandom_range(20000, 34000)),
               24'($urandom_range(6000000, 12000000))});
         else
            pending_readings.push_back({16'($urandom), 24'($urandom)});
      end
   endtask

   initial begin
      for (int i = 0; i < NUM_CFG; i++) cal[i] = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      // all-zero calibration: temperature divisor is zero
      pending_readings.push_back({16'd27898, 24'd6067200});
      pending_readings.push_back({16'hffff, 24'hffffff});
      drain();
      load_typical(2'd0);
      pending_readings.push_back({16'd27898, 24'h5d2300});
      pending_readings.push_back({16'd0, 24'd0});
      pending_readings.push_back({16'hffff, 24'hffffff});
      pending_readings.push_back({16'h8000, 24'h800000});
      pending_readings.push_back({16'h5555, 24'haaaaaa});
      pending_readings.push_back({16'haaaa, 24'h555555});
      drain();
      // ac4 zero gives a zero pressure divisor
      csr_write(REG_AC3_AC4, {-16'sd14383, 16'd0});
      pending_readings.push_back({16'd27898, 24'd6067200});
      // md chosen so that x1 + md is zero with ac5 zero
      drain();
      csr_write(REG_AC5_AC6, 32'd0);
      csr_write(REG_MC_MD, 32'd0);
      pending_readings.push_back({16'd1234, 24'd1});
      drain();
      // extreme calibration words
      csr_write(REG_AC1_AC2, 32'h7fff_8000);
      csr_write(REG_AC3_AC4, 32'h8000_ffff);
      csr_write(REG_AC5_AC6, 32'hffff_ffff);
      csr_write(REG_B1_B2, 32'h7fff_7fff);
      csr_write(REG_MC_MD, 32'h8000_7fff);
      csr_write(REG_OSS, 32'hffff_ffff);
      pending_readings.push_back({16'd0, 24'hffffff});
      pending_readings.push_back({16'hffff, 24'd0});
      drain();
      for (int ph = 0; ph < 4; ph++) begin
         load_typical(2'(ph));
         queue_random(70, 1'b1);
         queue_random(15, 1'b0);
         if (ph == 1) drain();
         drain();
         for (int i = 0; i < NUM_CFG; i++) csr_write(i, $urandom);
         queue_random(15, 1'b0);
         drain();
      end
      calm = 1'b1;
      load_typical(2'd3);
      queue_random(40, 1'b1);
      drain();
      $display("checked %0d compensated readings over four oversampling settings, %0d faults",
         checked, faults_seen);
      if (mismatches == 0) $display("TEST PASSED");
      else $display("TEST FAILED");
      $finish;
   end

   initial begin
      #2ms;
      $display("TEST FAILED");
      $finish;
   end
endmodule
